FILE: sv/skrt_pkg.sv
// Shared types and constants for the sorted keyed record table.
package skrt_pkg;

    // Table size and the widths that follow from it.
    localparam int CAPACITY = 128;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int KEY_W = 16;
    localparam int VAL_W = 32;
    localparam int OUT_CNT_W = 8;

    // Operation codes.
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_SEARCH = 2'd1,
        FN_ADD    = 2'd2,
        FN_SET    = 2'd3
    } t_func;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EXISTS  = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    // One stored record.
    typedef struct packed {
        logic        [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] price;
        logic signed [VAL_W-1:0] qty;
    } t_rec;

    // Request from the sequencer to the record store.
    typedef struct packed {
        logic [IDX_W-1:0] rd_addr;
        logic             we;
        logic [IDX_W-1:0] wr_addr;
        t_rec             wdata;
    } t_mem_req;

    // Status and result from the sequencer to the output stage.
    typedef struct packed {
        logic                    busy;
        logic                    done;
        t_status                 status;
        logic signed [VAL_W-1:0] price;
        logic signed [VAL_W-1:0] qty;
        logic [CNT_W-1:0]        count;
    } t_seq_stat;

endpackage

FILE: sv/skrt_store.sv
// Record memory: one write port and one registered read port.
module skrt_store (
    input  logic              i_clk,
    input  skrt_pkg::t_mem_req i_req,
    output skrt_pkg::t_rec    o_rdata
);

    skrt_pkg::t_rec mem [skrt_pkg::CAPACITY];
    skrt_pkg::t_rec r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.wr_addr] <= i_req.wdata;
        end
    end

    // Read port, registered: data follows in the cycle after the address.
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_req.rd_addr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/skrt_seq.sv
// Sequencer: walks the table one entry a cycle, comparing each entry's key with the request key.
module skrt_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic [1:0]                     i_func,
    input  logic [skrt_pkg::KEY_W-1:0]     i_key,
    input  logic signed [skrt_pkg::VAL_W-1:0] i_price,
    input  logic signed [skrt_pkg::VAL_W-1:0] i_qty,
    input  logic                           i_take,
    input  skrt_pkg::t_rec                 i_rdata,
    output skrt_pkg::t_mem_req             o_req,
    output skrt_pkg::t_seq_stat            o_stat
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT_PRE,
        S_SHIFT,
        S_INSERT,
        S_UPDATE,
        S_DONE
    } t_state;

    t_state                              r_state, n_state;
    skrt_pkg::t_func                     r_func, n_func;
    logic [skrt_pkg::KEY_W-1:0]          r_key, n_key;
    logic signed [skrt_pkg::VAL_W-1:0]   r_price_in, n_price_in;
    logic signed [skrt_pkg::VAL_W-1:0]   r_qty_in, n_qty_in;
    logic [skrt_pkg::IDX_W-1:0]          r_ptr, n_ptr;
    logic [skrt_pkg::IDX_W-1:0]          r_idx, n_idx;
    logic [skrt_pkg::CNT_W-1:0]          r_count, n_count;
    skrt_pkg::t_status                   r_status, n_status;
    logic signed [skrt_pkg::VAL_W-1:0]   r_pout, n_pout;
    logic signed [skrt_pkg::VAL_W-1:0]   r_qout, n_qout;

    logic                                w_last;
    logic [skrt_pkg::VAL_W:0]            w_sum;
    logic signed [skrt_pkg::VAL_W-1:0]   w_sat;

    // The scan has reached the last held entry.
    assign w_last = ((skrt_pkg::CNT_W'(r_ptr) + skrt_pkg::CNT_W'(1)) == r_count);

    // Saturating add of the stored quantity and the delta.
    assign w_sum = {r_qout[skrt_pkg::VAL_W-1], r_qout}
                 + {r_qty_in[skrt_pkg::VAL_W-1], r_qty_in};
    always_comb begin
        if (w_sum[skrt_pkg::VAL_W] != w_sum[skrt_pkg::VAL_W-1]) begin
            w_sat = w_sum[skrt_pkg::VAL_W]
                  ? {1'b1, {(skrt_pkg::VAL_W-1){1'b0}}}
                  : {1'b0, {(skrt_pkg::VAL_W-1){1'b1}}};
        end else begin
            w_sat = w_sum[skrt_pkg::VAL_W-1:0];
        end
    end

    // Next state and memory requests.
    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_key      = r_key;
        n_price_in = r_price_in;
        n_qty_in   = r_qty_in;
        n_ptr      = r_ptr;
        n_idx      = r_idx;
        n_count    = r_count;
        n_status   = r_status;
        n_pout     = r_pout;
        n_qout     = r_qout;

        o_req.rd_addr = '0;
        o_req.we      = 1'b0;
        o_req.wr_addr = r_idx;
        o_req.wdata   = i_rdata;

        case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_func     = skrt_pkg::t_func'(i_func);
                    n_key      = i_key;
                    n_price_in = i_price;
                    n_qty_in   = i_qty;
                    n_ptr      = '0;
                    n_idx      = '0;
                    n_status   = skrt_pkg::ST_OK;
                    n_pout     = '0;
                    n_qout     = '0;
                    if (skrt_pkg::t_func'(i_func) == skrt_pkg::FN_INSERT &&
                        r_count == skrt_pkg::CNT_W'(skrt_pkg::CAPACITY)) begin
                        n_status = skrt_pkg::ST_FULL;
                        n_state  = S_DONE;
                    end else if (r_count == '0) begin
                        if (skrt_pkg::t_func'(i_func) == skrt_pkg::FN_INSERT) begin
                            n_state = S_INSERT;
                        end else begin
                            n_status = skrt_pkg::ST_MISSING;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // Data of entry r_ptr is here; fetch the following entry.
                o_req.rd_addr = r_ptr + skrt_pkg::IDX_W'(1);
                if (i_rdata.key == r_key) begin
                    n_idx = r_ptr;
                    if (r_func == skrt_pkg::FN_INSERT) begin
                        n_status = skrt_pkg::ST_EXISTS;
                        n_state  = S_DONE;
                    end else begin
                        n_pout  = i_rdata.price;
                        n_qout  = i_rdata.qty;
                        n_state = S_UPDATE;
                    end
                end else if (i_rdata.key > r_key || w_last) begin
                    if (r_func != skrt_pkg::FN_INSERT) begin
                        n_status = skrt_pkg::ST_MISSING;
                        n_state  = S_DONE;
                    end else if (i_rdata.key > r_key) begin
                        // Larger entries move up, starting from the top.
                        n_idx   = r_ptr;
                        n_ptr   = r_count[skrt_pkg::IDX_W-1:0];
                        n_state = S_SHIFT_PRE;
                    end else begin
                        n_idx   = r_ptr + skrt_pkg::IDX_W'(1);
                        n_state = S_INSERT;
                    end
                end else begin
                    n_ptr = r_ptr + skrt_pkg::IDX_W'(1);
                end
            end
            S_SHIFT_PRE: begin
                o_req.rd_addr = r_ptr - skrt_pkg::IDX_W'(1);
                n_state       = S_SHIFT;
            end
            S_SHIFT: begin
                // Copy entry r_ptr-1 into r_ptr while fetching r_ptr-2.
                o_req.we      = 1'b1;
                o_req.wr_addr = r_ptr;
                o_req.wdata   = i_rdata;
                o_req.rd_addr = r_ptr - skrt_pkg::IDX_W'(2);
                if ((r_ptr - skrt_pkg::IDX_W'(1)) == r_idx) begin
                    n_state = S_INSERT;
                end else begin
                    n_ptr = r_ptr - skrt_pkg::IDX_W'(1);
                end
            end
            S_INSERT: begin
                o_req.we          = 1'b1;
                o_req.wr_addr     = r_idx;
                o_req.wdata.key   = r_key;
                o_req.wdata.price = r_price_in;
                o_req.wdata.qty   = r_qty_in;
                n_count = r_count + skrt_pkg::CNT_W'(1);
                n_pout  = r_price_in;
                n_qout  = r_qty_in;
                n_state = S_DONE;
            end
            S_UPDATE: begin
                o_req.we          = (r_func != skrt_pkg::FN_SEARCH);
                o_req.wr_addr     = r_idx;
                o_req.wdata.key   = r_key;
                o_req.wdata.price = (r_func == skrt_pkg::FN_SET) ? r_price_in : r_pout;
                o_req.wdata.qty   = (r_func == skrt_pkg::FN_ADD) ? w_sat : r_qout;
                n_pout  = o_req.wdata.price;
                n_qout  = o_req.wdata.qty;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and registered results.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
        r_func     <= n_func;
        r_key      <= n_key;
        r_price_in <= n_price_in;
        r_qty_in   <= n_qty_in;
        r_ptr      <= n_ptr;
        r_idx      <= n_idx;
        r_status   <= n_status;
        r_pout     <= n_pout;
        r_qout     <= n_qout;
    end

    assign o_stat.busy   = (r_state != S_IDLE);
    assign o_stat.done   = (r_state == S_DONE);
    assign o_stat.status = r_status;
    assign o_stat.price  = r_pout;
    assign o_stat.qty    = r_qout;
    assign o_stat.count  = r_count;

endmodule

FILE: sv/sorted_keyed_record_table.sv
// Top level: sorted keyed record table with request and result channels.
//
//  channel   direction  handshake           beat contents
//  request   in         i_valid / o_stall   i_func, i_part_key, i_price_in, i_quantity_in
//  result    out        o_valid / i_stall   o_status, o_price_out, o_quantity_out,
//                                           o_entry_count_out
//
// A request scans the held entries in key order from the lowest; an insert that
// moves entries up then copies each larger entry one place higher, from the top
// down, before the new record is written. The single read port of the record memory,
// one entry a cycle, paces both; scan and moves together cover at most CAPACITY entries.
// Reset is synchronous and active low; it empties the table. Memory contents
// are not cleared: only entries below the fill count are ever used.
// While a request is in work o_stall is high. A finished result waits in the
// output register while i_stall is high, and the next request can be accepted.
module sorted_keyed_record_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [1:0]                        i_func,
    input  logic [skrt_pkg::KEY_W-1:0]        i_part_key,
    input  logic signed [skrt_pkg::VAL_W-1:0] i_price_in,
    input  logic signed [skrt_pkg::VAL_W-1:0] i_quantity_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [1:0]                        o_status,
    output logic signed [skrt_pkg::VAL_W-1:0] o_price_out,
    output logic signed [skrt_pkg::VAL_W-1:0] o_quantity_out,
    output logic [skrt_pkg::OUT_CNT_W-1:0]    o_entry_count_out
);

    skrt_pkg::t_mem_req  w_req;
    skrt_pkg::t_rec      w_rdata;
    skrt_pkg::t_seq_stat w_stat;
    logic                w_accept;
    logic                w_take;
    logic [skrt_pkg::CNT_W+skrt_pkg::OUT_CNT_W-1:0] w_cnt_ext;

    logic                              r_out_valid;
    skrt_pkg::t_status                 r_status;
    logic signed [skrt_pkg::VAL_W-1:0] r_price;
    logic signed [skrt_pkg::VAL_W-1:0] r_qty;
    logic [skrt_pkg::OUT_CNT_W-1:0]    r_cnt;

    assign o_stall  = w_stat.busy;
    assign w_accept = i_valid && !w_stat.busy;
    assign w_take   = w_stat.done && (!r_out_valid || !i_stall);

    skrt_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_func   (i_func),
        .i_key    (i_part_key),
        .i_price  (i_price_in),
        .i_qty    (i_quantity_in),
        .i_take   (w_take),
        .i_rdata  (w_rdata),
        .o_req    (w_req),
        .o_stat   (w_stat)
    );

    skrt_store u_store (
        .i_clk   (i_clk),
        .i_req   (w_req),
        .o_rdata (w_rdata)
    );

    // The reported count is the fill count masked to eight bits.
    assign w_cnt_ext = {{skrt_pkg::OUT_CNT_W{1'b0}}, w_stat.count};

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
        if (w_take) begin
            r_status <= w_stat.status;
            r_price  <= w_stat.price;
            r_qty    <= w_stat.qty;
            r_cnt    <= w_cnt_ext[skrt_pkg::OUT_CNT_W-1:0];
        end
    end

    assign o_valid           = r_out_valid;
    assign o_status          = r_status;
    assign o_price_out       = r_price;
    assign o_quantity_out    = r_qty;
    assign o_entry_count_out = r_cnt;

    // The fill count never exceeds the table size.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.count <= skrt_pkg::CNT_W'(skrt_pkg::CAPACITY))
        else $error("fill count beyond table size");

    // A refused or missing request reports zero price and quantity.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != skrt_pkg::ST_OK) |->
        (o_price_out == '0 && o_quantity_out == '0))
        else $error("nonzero payload on failed request");

    // An accepted request keeps the sequencer busy in the next cycle.
    a_busy_after: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_stall)
        else $error("sequencer not busy after accept");

    // The fill count changes only by one insert at a time.
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stat.count != $past(w_stat.count)) |->
        (w_stat.count == $past(w_stat.count) + skrt_pkg::CNT_W'(1)))
        else $error("fill count jumped");

endmodule

FILE: tb/tb_sorted_keyed_record_table.sv
// Self-checking testbench for the sorted keyed record table: directed and random requests.
module tb_sorted_keyed_record_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint QTY_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint QTY_MIN = -64'sh0000_0000_8000_0000;
    localparam int DRAIN_CYCLES = 2 * skrt_pkg::CAPACITY + 10;
    localparam int RANDOM_BEATS = 1000;

    // One expected result beat.
    typedef struct {
        skrt_pkg::t_status                 status;
        logic signed [skrt_pkg::VAL_W-1:0] price;
        logic signed [skrt_pkg::VAL_W-1:0] qty;
        logic [skrt_pkg::OUT_CNT_W-1:0]    count;
    } t_table_reply;

    // Shadow copy of the table that predicts every result and checks it on arrival.
    class t_record_table_shadow;
        logic [skrt_pkg::KEY_W-1:0]        keys[skrt_pkg::CAPACITY];
        logic signed [skrt_pkg::VAL_W-1:0] prices[skrt_pkg::CAPACITY];
        logic signed [skrt_pkg::VAL_W-1:0] qtys[skrt_pkg::CAPACITY];
        int                                fill;
        t_table_reply                      pending_replies[$];
        int                                mismatch_count;

        function new();
            fill = 0;
            mismatch_count = 0;
        endfunction

        // Slot of a held key, or the fill count when the key is absent.
        function int find_key(logic [skrt_pkg::KEY_W-1:0] key);
            for (int i = 0; i < fill; i++)
                if (keys[i] == key)
                    return i;
            return fill;
        endfunction

        // A key already in the table, or any key while the table is empty.
        function logic [skrt_pkg::KEY_W-1:0] pick_held_key();
            if (fill == 0)
                return skrt_pkg::KEY_W'($urandom);
            return keys[$urandom_range(fill - 1)];
        endfunction

        // Apply one accepted request and queue the result it must produce.
        function void apply_request(skrt_pkg::t_func func,
                                    logic [skrt_pkg::KEY_W-1:0] key,
                                    logic signed [skrt_pkg::VAL_W-1:0] price,
                                    logic signed [skrt_pkg::VAL_W-1:0] qty);
            t_table_reply r;
            int           slot;
            longint       total;
            r.status = skrt_pkg::ST_OK;
            r.price  = '0;
            r.qty    = '0;
            if (func == skrt_pkg::FN_INSERT) begin
                if (fill >= skrt_pkg::CAPACITY) begin
                    r.status = skrt_pkg::ST_FULL;
                end else if (find_key(key) < fill) begin
                    r.status = skrt_pkg::ST_EXISTS;
                end else begin
                    // Open a gap above every smaller key and drop the record in.
                    slot = 0;
                    while (slot < fill && keys[slot] < key)
                        slot++;
                    for (int k = fill; k > slot; k--) begin
                        keys[k]   = keys[k-1];
                        prices[k] = prices[k-1];
                        qtys[k]   = qtys[k-1];
                    end
                    keys[slot]   = key;
                    prices[slot] = price;
                    qtys[slot]   = qty;
                    fill++;
                    r.price = price;
                    r.qty   = qty;
                end
            end else begin
                slot = find_key(key);
                if (slot >= fill) begin
                    r.status = skrt_pkg::ST_MISSING;
                end else begin
                    if (func == skrt_pkg::FN_ADD) begin
                        // The quantity saturates at the signed 32-bit range.
                        total = longint'(qtys[slot]) + longint'(qty);
                        if (total > QTY_MAX)
                            total = QTY_MAX;
                        if (total < QTY_MIN)
                            total = QTY_MIN;
                        qtys[slot] = total[skrt_pkg::VAL_W-1:0];
                    end else if (func == skrt_pkg::FN_SET) begin
                        prices[slot] = price;
                    end
                    r.price = prices[slot];
                    r.qty   = qtys[slot];
                end
            end
            r.count = skrt_pkg::OUT_CNT_W'(fill);
            pending_replies.push_back(r);
        endfunction

        function void report_field(string field, longint exp_val, longint act_val);
            if (exp_val != act_val) begin
                mismatch_count++;
                $display("%0t: %s expected %0d, actual %0d", $time, field, exp_val, act_val);
            end
        endfunction

        // Compare one result beat with the oldest prediction.
        function void check_reply(skrt_pkg::t_status status,
                                  logic signed [skrt_pkg::VAL_W-1:0] price,
                                  logic signed [skrt_pkg::VAL_W-1:0] qty,
                                  logic [skrt_pkg::OUT_CNT_W-1:0] count);
            t_table_reply r;
            if (pending_replies.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, expected none, actual %s %0d %0d %0d",
                         $time, status.name(), price, qty, count);
                return;
            end
            r = pending_replies.pop_front();
            report_field("status", longint'(r.status), longint'(status));
            report_field("price", longint'(r.price), longint'(price));
            report_field("quantity", longint'(r.qty), longint'(qty));
            report_field("entry count", longint'(r.count), longint'(count));
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_stall;
    logic [1:0]                        i_func;
    logic [skrt_pkg::KEY_W-1:0]        i_part_key;
    logic signed [skrt_pkg::VAL_W-1:0] i_price_in;
    logic signed [skrt_pkg::VAL_W-1:0] i_quantity_in;
    logic                              o_valid;
    logic                              i_stall;
    logic [1:0]                        o_status;
    logic signed [skrt_pkg::VAL_W-1:0] o_price_out;
    logic signed [skrt_pkg::VAL_W-1:0] o_quantity_out;
    logic [skrt_pkg::OUT_CNT_W-1:0]    o_entry_count_out;

    // No random idling on either side while this is set.
    bit quiet;

    t_record_table_shadow shadow = new();

    sorted_keyed_record_table dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_func            (i_func),
        .i_part_key        (i_part_key),
        .i_price_in        (i_price_in),
        .i_quantity_in     (i_quantity_in),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_status          (o_status),
        .o_price_out       (o_price_out),
        .o_quantity_out    (o_quantity_out),
        .o_entry_count_out (o_entry_count_out)
    );

    // 50 MHz clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The result side stalls now and then.
    always @(negedge i_clk) begin
        i_stall <= !quiet && ($urandom_range(99) < 6);
    end

    // Every result beat is checked as it is taken.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            shadow.check_reply(skrt_pkg::t_status'(o_status), o_price_out, o_quantity_out,
                               o_entry_count_out);
    end

    // Present one request beat, hold it until taken, and tell the shadow table.
    task automatic send_request(skrt_pkg::t_func func, logic [skrt_pkg::KEY_W-1:0] key,
                                logic signed [skrt_pkg::VAL_W-1:0] price,
                                logic signed [skrt_pkg::VAL_W-1:0] qty);
        while (!quiet && $urandom_range(99) < 6) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_func        <= func;
        i_part_key    <= key;
        i_price_in    <= price;
        i_quantity_in <= qty;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        shadow.apply_request(func, key, price, qty);
        @(negedge i_clk);
    endtask

    // Mostly well-formed traffic on held keys, with fresh and duplicate inserts.
    task automatic random_request();
        skrt_pkg::t_func                   func;
        logic [skrt_pkg::KEY_W-1:0]        key;
        logic signed [skrt_pkg::VAL_W-1:0] price;
        logic signed [skrt_pkg::VAL_W-1:0] qty;
        int                                pick;
        pick = $urandom_range(99);
        if (pick < 30)
            func = skrt_pkg::FN_INSERT;
        else if (pick < 55)
            func = skrt_pkg::FN_SEARCH;
        else if (pick < 80)
            func = skrt_pkg::FN_ADD;
        else
            func = skrt_pkg::FN_SET;
        if (func == skrt_pkg::FN_INSERT)
            key = ($urandom_range(99) < 20) ? shadow.pick_held_key()
                                            : skrt_pkg::KEY_W'($urandom);
        else
            key = ($urandom_range(99) < 75) ? shadow.pick_held_key()
                                            : skrt_pkg::KEY_W'($urandom);
        if ($urandom_range(19) == 0)
            key = $urandom_range(1) ? '1 : '0;
        price = $urandom;
        // Deltas are small, arbitrary or at the range ends so saturation is hit often.
        case ($urandom_range(2))
            0: qty = $signed($urandom_range(2000)) - 1000;
            1: qty = $urandom;
            default: qty = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        endcase
        send_request(func, key, price, qty);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_func        = skrt_pkg::FN_SEARCH;
        i_part_key    = '0;
        i_price_in    = '0;
        i_quantity_in = '0;
        quiet         = 1'b0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Requests on an empty table find nothing.
        send_request(skrt_pkg::FN_SEARCH, 16'h0000, 32'sd5, 32'sd6);
        send_request(skrt_pkg::FN_ADD, 16'hFFFF, 32'sd0, 32'sd1);
        send_request(skrt_pkg::FN_SET, 16'h1234, 32'sd77, 32'sd0);
        // Inserts at the key and value extremes, a duplicate, and one in the middle.
        send_request(skrt_pkg::FN_INSERT, 16'h8000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        send_request(skrt_pkg::FN_INSERT, 16'h0000, 32'sh8000_0000, 32'sh8000_0000);
        send_request(skrt_pkg::FN_INSERT, 16'hFFFF, -32'sd1, 32'sd1);
        send_request(skrt_pkg::FN_INSERT, 16'h8000, 32'sd1, 32'sd1);
        send_request(skrt_pkg::FN_INSERT, 16'h4000, 32'sd100, 32'sd100);
        send_request(skrt_pkg::FN_SEARCH, 16'h0000, 32'sd0, 32'sd0);
        send_request(skrt_pkg::FN_SEARCH, 16'hFFFF, 32'sd0, 32'sd0);
        send_request(skrt_pkg::FN_SEARCH, 16'h7FFF, 32'sd0, 32'sd0);
        // Saturation at both ends of the quantity range, mixed with plain sums.
        send_request(skrt_pkg::FN_ADD, 16'h8000, 32'sd0, 32'sd1);
        send_request(skrt_pkg::FN_ADD, 16'h0000, 32'sd0, -32'sd1);
        send_request(skrt_pkg::FN_ADD, 16'h8000, 32'sd0, 32'sh8000_0000);
        send_request(skrt_pkg::FN_ADD, 16'h4000, 32'sd0, 32'sh7FFF_FFFF);
        send_request(skrt_pkg::FN_ADD, 16'h4000, 32'sd0, -32'sd50);
        // Price updates at the extremes.
        send_request(skrt_pkg::FN_SET, 16'h8000, 32'sh8000_0000, 32'sd9);
        send_request(skrt_pkg::FN_SET, 16'hFFFF, 32'sh7FFF_FFFF, 32'sd9);
        send_request(skrt_pkg::FN_INSERT, 16'hFFFE, 32'sd3, -32'sd3);
        send_request(skrt_pkg::FN_SEARCH, 16'h4000, 32'sd0, 32'sd0);
        send_request(skrt_pkg::FN_SEARCH, 16'hFFFE, 32'sd0, 32'sd0);

        // Let the block drain completely once before the random traffic.
        i_valid <= 1'b0;
        while (shadow.pending_replies.size() != 0)
            @(negedge i_clk);

        // Random traffic fills the table, after which inserts report it full.
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            quiet = (n >= 300 && n < 450);
            random_request();
        end
        quiet = 1'b0;
        i_valid <= 1'b0;

        while (shadow.pending_replies.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (shadow.mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #30ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

FILE: sorted_keyed_record_table.f
sv/skrt_pkg.sv
sv/skrt_store.sv
sv/skrt_seq.sv
sv/sorted_keyed_record_table.sv
tb/tb_sorted_keyed_record_table.sv
